[rtl/core/matrix_inverse_3x3_defines.svh]
// Assertion macros shared by the 3x3 matrix inverse RTL.
// Depends on nothing; files that assert include it and must have clk and arst_n in scope.
`ifndef MATRIX_INVERSE_3X3_DEFINES_SVH
`define MATRIX_INVERSE_3X3_DEFINES_SVH
`ifndef SYNTHESIS
// Property holds at every clock edge outside reset.
`define MI3_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Expression is never true outside reset.
`define MI3_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define MI3_ASSERT(lbl, prop, msg)
`define MI3_NEVER(lbl, expr, msg)
`endif
`endif

[rtl/core/mi3_pkg.sv]
// Types, widths and helper functions for the 3x3 matrix inverse.
// Depends on nothing; used by every module of the block.
package mi3_pkg;
	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;
	// Product, adjugate and determinant widths.
	localparam int PW   = 2 * DATA_WIDTH;
	localparam int AW   = PW + 1;
	localparam int DETW = DATA_WIDTH + AW + 2;
	// Quotient bits of the doubled quotient, numerator and remainder widths.
	localparam int QB   = DATA_WIDTH + 1;
	localparam int MW   = AW + 2 * FRAC_BITS + 1;
	localparam int RW   = DETW + QB;
	// Latency of one divider lane, input register to result register.
	localparam int LANE_LAT = QB + 2;
	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = $clog2(QDEPTH);

	typedef logic signed [DATA_WIDTH-1:0] word_t;
	typedef logic signed [AW-1:0] adj_t;
	typedef logic signed [DETW-1:0] det_t;

	// One word passed from the front part to the back part.
	typedef struct packed {
		word_t [8:0] a;
		adj_t [8:0] adj;
		det_t det;
	} job_t;

	typedef struct packed {
		logic sat;
		word_t val;
	} rsat_t;

	// Cofactor operands: adj[k] = a[p]*a[q] - a[s]*a[t].
	localparam int MINOR_IDX [9][4] = '{
		'{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
		'{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
		'{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}};

	// Apply a sign to a rounded magnitude and clip it to the word range.
	function automatic rsat_t clip(input logic neg, input logic [DETW:0] mag);
		logic [DETW:0] half;
		rsat_t r;
		half = (DETW + 1)'(1) << (DATA_WIDTH - 1);
		if (!neg && mag >= half) begin
			r = '{sat: 1'b1, val: {1'b0, {(DATA_WIDTH - 1){1'b1}}}};
		end else if (neg && mag > half) begin
			r = '{sat: 1'b1, val: {1'b1, {(DATA_WIDTH - 1){1'b0}}}};
		end else if (neg) begin
			r = '{sat: 1'b0, val: word_t'((~mag[DATA_WIDTH-1:0]) + 1'b1)};
		end else begin
			r = '{sat: 1'b0, val: word_t'(mag[DATA_WIDTH-1:0])};
		end
		return r;
	endfunction
endpackage

[rtl/core/matrix_inverse_3x3.sv]
// 3x3 matrix inverse, Q16.16: one matrix word is accepted per clock unless in_stall is set,
// and one result word leaves per clock unless out_stall holds it, in order. A word passes
// 4 front stages, the queue and 2 + DATA_WIDTH + 2 back stages, a length set by the nine
// bit-per-stage divider lanes. A singular matrix comes back unchanged with the singular
// flag, and entries and determinant are rounded to nearest and clipped.
// Depends on mi3_pkg, mi3_front, mi3_queue, mi3_div_lane and mi3_back.
module matrix_inverse_3x3 (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  mi3_pkg::word_t a00,
	input  mi3_pkg::word_t a01,
	input  mi3_pkg::word_t a02,
	input  mi3_pkg::word_t a10,
	input  mi3_pkg::word_t a11,
	input  mi3_pkg::word_t a12,
	input  mi3_pkg::word_t a20,
	input  mi3_pkg::word_t a21,
	input  mi3_pkg::word_t a22,
	output logic out_valid,
	input  logic out_stall,
	output mi3_pkg::word_t r00,
	output mi3_pkg::word_t r01,
	output mi3_pkg::word_t r02,
	output mi3_pkg::word_t r10,
	output mi3_pkg::word_t r11,
	output mi3_pkg::word_t r12,
	output mi3_pkg::word_t r20,
	output mi3_pkg::word_t r21,
	output mi3_pkg::word_t r22,
	output logic singular,
	output mi3_pkg::word_t determinant,
	output logic saturated
);
	import mi3_pkg::*;

	word_t [8:0] a_in;
	word_t [8:0] r;
	job_t f_job, q_job;
	logic f_valid, q_full, q_valid, q_pop;

	assign a_in = {a22, a21, a20, a12, a11, a10, a02, a01, a00};

	mi3_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.a_in(a_in),
		.job_valid(f_valid),
		.job(f_job),
		.job_full(q_full)
	);

	mi3_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(f_valid),
		.din(f_job),
		.full(q_full),
		.valid(q_valid),
		.dout(q_job),
		.pop(q_pop)
	);

	mi3_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.job_valid(q_valid),
		.job(q_job),
		.job_pop(q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.r(r),
		.singular(singular),
		.determinant(determinant),
		.saturated(saturated)
	);

	assign r00 = r[0];
	assign r01 = r[1];
	assign r02 = r[2];
	assign r10 = r[3];
	assign r11 = r[4];
	assign r12 = r[5];
	assign r20 = r[6];
	assign r21 = r[7];
	assign r22 = r[8];
endmodule

[rtl/core/mi3_front.sv]
// Front part: cofactors and determinant of each accepted matrix, four stages.
// Depends on mi3_pkg.
module mi3_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  mi3_pkg::word_t [8:0] a_in,
	output logic job_valid,
	output mi3_pkg::job_t job,
	input  logic job_full
);
	import mi3_pkg::*;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4;
	word_t [8:0] a_s1, a_s2, a_s3, a_s4;
	logic signed [PW-1:0] pp_s1 [9];
	logic signed [PW-1:0] pq_s1 [9];
	adj_t [8:0] adj_s2, adj_s3, adj_s4;
	logic signed [PW:0] dlo_s3 [3];
	logic signed [PW:0] dhi_s3 [3];
	det_t det_s4;
	det_t det_sum;

	// The whole pipeline holds while its last word waits on a full queue.
	assign en = !(v_s4 && job_full);
	assign in_stall = !en;
	assign job_valid = v_s4;
	assign job = '{a: a_s4, adj: adj_s4, det: det_s4};

	// Valid bits of the four stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Determinant adds the three split products along the first row.
	always_comb begin
		det_sum = '0;
		for (int j = 0; j < 3; j++) begin
			det_sum = det_sum + (DETW'(dhi_s3[j]) <<< DATA_WIDTH) + DETW'(dlo_s3[j]);
		end
	end

	// Stage 1 forms cofactor products, stage 2 the cofactors, stage 3 the
	// determinant partial products, stage 4 their sum.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++) begin
				pp_s1[k] <= $signed(a_in[MINOR_IDX[k][0]]) * $signed(a_in[MINOR_IDX[k][1]]);
				pq_s1[k] <= $signed(a_in[MINOR_IDX[k][2]]) * $signed(a_in[MINOR_IDX[k][3]]);
				adj_s2[k] <= AW'(pp_s1[k]) - AW'(pq_s1[k]);
			end
			for (int j = 0; j < 3; j++) begin
				dlo_s3[j] <= $signed(a_s2[j]) * $signed({1'b0, adj_s2[3*j][DATA_WIDTH-1:0]});
				dhi_s3[j] <= $signed(a_s2[j]) * $signed(adj_s2[3*j][AW-1:DATA_WIDTH]);
			end
			a_s1 <= a_in;
			a_s2 <= a_s1;
			a_s3 <= a_s2;
			a_s4 <= a_s3;
			adj_s3 <= adj_s2;
			adj_s4 <= adj_s3;
			det_s4 <= det_sum;
		end
	end
endmodule

[rtl/core/mi3_queue.sv]
// Short queue of words between the front and back parts.
// Depends on mi3_pkg and matrix_inverse_3x3_defines.svh.
`include "matrix_inverse_3x3_defines.svh"
module mi3_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  mi3_pkg::job_t din,
	output logic full,
	output logic valid,
	output mi3_pkg::job_t dout,
	input  logic pop
);
	import mi3_pkg::*;

	job_t mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0] cnt_q;
	logic do_push, do_pop;

	assign full = (cnt_q == (QPTR_W + 1)'(QDEPTH));
	assign valid = (cnt_q != '0);
	assign dout = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop = pop && valid;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (QPTR_W + 1)'(do_push) - (QPTR_W + 1)'(do_pop);
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

	`MI3_NEVER(a_cnt_range, cnt_q > (QPTR_W + 1)'(QDEPTH), "queue count beyond depth")
	`MI3_ASSERT(a_ptr_gap, (QPTR_W'(wr_q - rd_q) == cnt_q[QPTR_W-1:0]), "pointers disagree with count")
	`MI3_ASSERT(a_full_hold, (full && !pop) |=> full, "full queue lost a word without a pop")
endmodule

[rtl/core/mi3_div_lane.sv]
// One pipelined divider lane: rounded, clipped quotient of a scaled cofactor by the determinant.
// Depends on mi3_pkg.
module mi3_div_lane (
	input  logic clk,
	input  logic en,
	input  logic [mi3_pkg::MW-1:0] m,
	input  logic [mi3_pkg::DETW-1:0] d,
	input  logic neg,
	output mi3_pkg::rsat_t res
);
	import mi3_pkg::*;

	logic [RW-1:0] rem_q [QB+1];
	logic [QB-1:0] quo_q [QB+1];
	logic [DETW-1:0] d_q [QB+1];
	logic neg_q [QB+1];
	logic ovf_q [QB+1];
	logic [QB:0] qr;

	// Entry: a doubled quotient of more than QB bits means overflow.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= RW'(m);
			quo_q[0] <= '0;
			d_q[0] <= d;
			neg_q[0] <= neg;
			ovf_q[0] <= (RW'(m) >= (RW'(d) << QB));
		end
	end

	// One quotient bit per stage, most significant first.
	for (genvar i = 0; i < QB; i++) begin : g_step
		logic [RW-1:0] sh;
		logic ge;
		assign sh = RW'(d_q[i]) << (QB - 1 - i);
		assign ge = (rem_q[i] >= sh);
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[i+1] <= ge ? (rem_q[i] - sh) : rem_q[i];
				quo_q[i+1] <= quo_q[i] | (ge ? (QB'(1) << (QB - 1 - i)) : '0);
				d_q[i+1] <= d_q[i];
				neg_q[i+1] <= neg_q[i];
				ovf_q[i+1] <= ovf_q[i];
			end
		end
	end

	// The low bit of the doubled quotient is the round-half-up bit.
	assign qr = ((QB + 1)'(quo_q[QB]) + 1'b1) >> 1;

	// Result register.
	always_ff @(posedge clk) begin
		if (en) begin
			if (ovf_q[QB]) begin
				res <= '{sat: 1'b1, val: neg_q[QB] ? {1'b1, {(DATA_WIDTH - 1){1'b0}}}
					: {1'b0, {(DATA_WIDTH - 1){1'b1}}}};
			end else begin
				res <= clip(neg_q[QB], (DETW + 1)'(qr));
			end
		end
	end
endmodule

[rtl/core/mi3_back.sv]
// Back part: magnitudes, nine divider lanes, determinant rounding and the result word.
// Depends on mi3_pkg and mi3_div_lane.
module mi3_back (
	input  logic clk,
	input  logic arst_n,
	input  logic job_valid,
	input  mi3_pkg::job_t job,
	output logic job_pop,
	output logic out_valid,
	input  logic out_stall,
	output mi3_pkg::word_t [8:0] r,
	output logic singular,
	output mi3_pkg::word_t determinant,
	output logic saturated
);
	import mi3_pkg::*;

	localparam int SL = LANE_LAT;

	logic en;
	logic v_s1;
	logic [MW-1:0] m_s1 [9];
	logic neg_s1 [9];
	logic [DETW-1:0] dmag_s1;
	logic dneg_s1;
	logic sg_s1;
	word_t [8:0] a_s1;
	logic [AW-1:0] amag [9];
	logic [DETW-1:0] dmag;
	logic [DETW:0] dround;
	rsat_t lane_res [9];
	logic sv_q [SL];
	logic sg_q [SL];
	word_t [8:0] raw_q [SL];
	rsat_t dw_q [SL];
	logic any_sat;

	// Everything moves together unless the result word is held.
	assign en = !(out_valid && out_stall);
	assign job_pop = job_valid && en;

	// Magnitudes of the cofactors and the determinant.
	always_comb begin
		for (int k = 0; k < 9; k++) begin
			amag[k] = job.adj[k][AW-1] ? AW'(-job.adj[k]) : AW'(job.adj[k]);
		end
		dmag = job.det[DETW-1] ? DETW'(-job.det) : DETW'(job.det);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= job_valid;
		end
	end

	// Operand stage: numerator is the cofactor scaled by twice 2^(2*FRAC_BITS).
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++) begin
				m_s1[k] <= MW'(amag[k]) << (2 * FRAC_BITS + 1);
				neg_s1[k] <= job.adj[k][AW-1] ^ job.det[DETW-1];
			end
			dmag_s1 <= dmag;
			dneg_s1 <= job.det[DETW-1];
			sg_s1 <= (job.det == '0);
			a_s1 <= job.a;
		end
	end

	for (genvar k = 0; k < 9; k++) begin : g_lane
		mi3_div_lane u_lane (
			.clk(clk),
			.en(en),
			.m(m_s1[k]),
			.d(dmag_s1),
			.neg(neg_s1[k]),
			.res(lane_res[k])
		);
	end

	// Determinant rounded to FRAC_BITS fraction bits, half away from zero.
	assign dround = ((DETW + 1)'(dmag_s1) + ((DETW + 1)'(1) << (2 * FRAC_BITS - 1)))
		>> (2 * FRAC_BITS);

	// Side line that keeps control and pass-through data in step with the lanes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < SL; j++) begin
				sv_q[j] <= 1'b0;
			end
		end else if (en) begin
			sv_q[0] <= v_s1;
			for (int j = 1; j < SL; j++) begin
				sv_q[j] <= sv_q[j-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sg_q[0] <= sg_s1;
			raw_q[0] <= a_s1;
			dw_q[0] <= clip(dneg_s1, dround);
			for (int j = 1; j < SL; j++) begin
				sg_q[j] <= sg_q[j-1];
				raw_q[j] <= raw_q[j-1];
				dw_q[j] <= dw_q[j-1];
			end
		end
	end

	// Result word: a singular matrix passes through unchanged.
	always_comb begin
		any_sat = dw_q[SL-1].sat;
		for (int k = 0; k < 9; k++) begin
			r[k] = sg_q[SL-1] ? raw_q[SL-1][k] : lane_res[k].val;
			any_sat = any_sat | lane_res[k].sat;
		end
	end

	assign out_valid = sv_q[SL-1];
	assign singular = sg_q[SL-1];
	assign determinant = sg_q[SL-1] ? '0 : dw_q[SL-1].val;
	assign saturated = sg_q[SL-1] ? 1'b0 : any_sat;
endmodule

[tb/tb_matrix_inverse_3x3.sv]
// Testbench for matrix_inverse_3x3: drives 3x3 Q16.16 matrices and checks inverse,
// determinant and flags against an exact wide-integer predictor.
// Depends on mi3_pkg and the matrix_inverse_3x3 RTL.
`timescale 1ns / 1ps

module tb_matrix_inverse_3x3;
	import mi3_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 80;

	typedef logic signed [255:0] big_t;

	typedef struct packed {
		word_t [8:0] r;
		logic sing;
		word_t det;
		logic sat;
	} inv_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	word_t a [9];
	logic out_valid;
	logic out_stall = 1'b0;
	word_t r [9];
	logic singular;
	word_t determinant;
	logic saturated;

	inv_word_t expected_q [$];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatches = 0;
	int results_seen = 0;
	int singular_seen = 0;
	int sat_seen = 0;
	int quiet_cycles = 0;

	initial for (int i = 0; i < 9; i++) a[i] = '0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	matrix_inverse_3x3 u_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.a00(a[0]), .a01(a[1]), .a02(a[2]), .a10(a[3]), .a11(a[4]), .a12(a[5]),
		.a20(a[6]), .a21(a[7]), .a22(a[8]),
		.out_valid(out_valid), .out_stall(out_stall),
		.r00(r[0]), .r01(r[1]), .r02(r[2]), .r10(r[3]), .r11(r[4]), .r12(r[5]),
		.r20(r[6]), .r21(r[7]), .r22(r[8]),
		.singular(singular), .determinant(determinant), .saturated(saturated)
	);

	// Rounded quotient n/d, ties away from zero, clipped to the word range.
	function automatic word_t round_div_clip(input big_t n, input big_t d, inout logic sat);
		big_t q, rem, mn, md;
		logic neg;
		mn = (n < 0) ? -n : n;
		md = (d < 0) ? -d : d;
		neg = (n < 0) != (d < 0);
		q = mn / md;
		rem = mn % md;
		if (2 * rem >= md) q = q + 1;
		if (!neg && q >= (big_t'(1) <<< 31)) begin
			sat = 1'b1;
			return 32'h7fffffff;
		end
		if (neg && q > (big_t'(1) <<< 31)) begin
			sat = 1'b1;
			return 32'h80000000;
		end
		return neg ? word_t'(-q) : word_t'(q);
	endfunction

	// Exact inverse of one matrix: cofactors, determinant, then the scaled quotients.
	function automatic inv_word_t predict_inverse(input word_t m [9]);
		int idx [9][4] = '{'{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
			'{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
			'{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}};
		big_t e [9];
		big_t cof [9];
		big_t det;
		inv_word_t res;
		logic sat;
		for (int i = 0; i < 9; i++) e[i] = big_t'(m[i]);
		for (int k = 0; k < 9; k++)
			cof[k] = e[idx[k][0]] * e[idx[k][1]] - e[idx[k][2]] * e[idx[k][3]];
		det = e[0] * cof[0] + e[1] * cof[3] + e[2] * cof[6];
		res = '0;
		if (det == 0) begin
			for (int i = 0; i < 9; i++) res.r[i] = m[i];
			res.sing = 1'b1;
			return res;
		end
		sat = 1'b0;
		for (int i = 0; i < 9; i++)
			res.r[i] = round_div_clip(cof[i] <<< (2 * FRAC_BITS), det, sat);
		res.det = round_div_clip(det, big_t'(1) <<< (2 * FRAC_BITS), sat);
		res.sat = sat;
		return res;
	endfunction

	// Send one matrix word and queue its expected result once accepted.
	// Valid stays high on return; the next word or an idle cycle replaces it.
	task automatic send_matrix(input word_t m [9]);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		for (int i = 0; i < 9; i++) a[i] <= m[i];
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_q.push_back(predict_inverse(m));
	endtask

	// Receiver stall pattern.
	always @(posedge clk) begin
		out_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
	end

	// Result checker and watchdog.
	always @(posedge clk) begin
		inv_word_t got, exp_w;
		if (arst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
			quiet_cycles <= 0;
		else if (arst_n)
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > WATCHDOG_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
			$display("matrix_inverse_3x3: mismatch");
			$finish;
		end
		if (arst_n && out_valid && !out_stall) begin
			for (int i = 0; i < 9; i++) got.r[i] = r[i];
			got.sing = singular;
			got.det = determinant;
			got.sat = saturated;
			results_seen++;
			if (got.sing) singular_seen++;
			if (got.sat) sat_seen++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word %p", got);
			end else begin
				exp_w = expected_q.pop_front();
				if (got !== exp_w) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d differs:\n  exp %p\n  got %p",
							results_seen, exp_w, got);
				end
			end
		end
	end

	function automatic word_t rand_entry();
		case ($urandom_range(5))
			0: return word_t'($urandom);
			1: return word_t'($signed($urandom_range(8)) - 4) <<< FRAC_BITS;
			2: return word_t'($signed($urandom_range(65535)) - 32768) <<< 8;
			3: return word_t'($signed($urandom_range(16)) - 8);
			default: return word_t'($signed($urandom_range(2000000)) - 1000000);
		endcase
	endfunction

	// Drop valid and wait until every expected result has come back.
	task automatic wait_empty();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
	endtask

	// Extremes, identity, singular, tiny and huge determinants.
	task automatic test_directed();
		word_t m [9];
		word_t one;
		one = word_t'(1) <<< FRAC_BITS;
		m = '{one, 0, 0, 0, one, 0, 0, 0, one};
		send_matrix(m);
		m = '{one * 2, 0, 0, 0, -one * 4, 0, 0, 0, one / 2};
		send_matrix(m);
		m = '{default: 0};
		send_matrix(m);
		m = '{default: 32'h7fffffff};
		send_matrix(m);
		m = '{one, 2 * one, 3 * one, 4 * one, 5 * one, 6 * one, 7 * one, 8 * one, 9 * one};
		send_matrix(m);
		m = '{32'h80000000, 0, 0, 0, 32'h80000000, 0, 0, 0, 32'h80000000};
		send_matrix(m);
		m = '{32'h7fffffff, 0, 0, 0, 32'h7fffffff, 0, 0, 0, 32'h7fffffff};
		send_matrix(m);
		m = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
		send_matrix(m);
		m = '{3, 0, 0, 0, -1, 0, 0, 0, 1};
		send_matrix(m);
		m = '{32'h80000000, 32'h7fffffff, 1, -1, 32'h80000000, 32'h7fffffff,
			5, -7, 32'h80000000};
		send_matrix(m);
		m = '{2 * one, one, 0, one, 2 * one, one, 0, one, 2 * one};
		send_matrix(m);
		m = '{0, one, 0, 0, 0, one, one, 0, 0};
		send_matrix(m);
		m = '{32'hffffffff, 32'h55555555, 32'haaaaaaaa, 32'h12345678, 32'hedcba987,
			32'h0f0f0f0f, 32'hf0f0f0f0, 32'h00010001, 32'h80000001};
		send_matrix(m);
		m = '{one, one, one, one, one, one, 0, 0, one};
		send_matrix(m);
	endtask

	// Random matrices, with some deliberately singular rows.
	task automatic test_random(input int count);
		word_t m [9];
		for (int n = 0; n < count; n++) begin
			for (int i = 0; i < 9; i++) m[i] = rand_entry();
			if ($urandom_range(9) == 0)
				for (int i = 0; i < 3; i++) m[3 + i] = m[i];
			send_matrix(m);
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		send_idle_pct = 19;
		recv_idle_pct = 81;
		test_random(380);
		// Sender holds off until the pipeline has drained completely.
		wait_empty();
		send_idle_pct = 81;
		recv_idle_pct = 19;
		test_random(380);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(380);
		wait_empty();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("checked %0d results: %0d singular, %0d with clipping",
			results_seen, singular_seen, sat_seen);
		if (mismatches == 0 && expected_q.size() == 0) begin
			$display("matrix_inverse_3x3: match");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, expected_q.size());
			$display("matrix_inverse_3x3: mismatch");
		end
		$finish;
	end
endmodule
